/* rtl/core/mie_pkg.sv */
package mie_pkg;

  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_NORM,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

/* rtl/core/mie_in_if.sv */
interface mie_in_if #(
  parameter int WORD_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

/* rtl/core/mie_out_if.sv */
interface mie_out_if #(
  parameter int WORD_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] inverse;
  logic                  no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

/* rtl/core/mie_cfg_if.sv */
interface mie_cfg_if #(
  parameter int WORD_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/mie_div.sv */
module mie_div #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  mie_pkg::div_ctrl_t    ctrl,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-1:0] divisor,
  input  logic [WORD_WIDTH-1:0] coef,
  output logic [WORD_WIDTH-1:0] rem,
  output logic [WORD_WIDTH-1:0] prod
);

  logic [WORD_WIDTH-1:0] p;
  logic [WORD_WIDTH-1:0] d;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;
  logic                  ge;

  always_comb begin
    trial = {p, d[WORD_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  // shift in one dividend bit, accumulate quotient times coef in Horner form
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p   <= '0;
      d   <= dividend;
      acc <= '0;
    end else if (ctrl.step) begin
      p   <= ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
      d   <= {d[WORD_WIDTH-2:0], 1'b0};
      acc <= {acc[WORD_WIDTH-2:0], 1'b0} + (ge ? coef : '0);
    end
  end

  assign rem  = p;
  assign prod = acc;

endmodule

/* rtl/core/modular_inverse_ext_euclid.sv */
// Modular inverse by the extended Euclidean algorithm.
// Channels: operand (sink) carries value; result (source) carries inverse
// and no_inverse; cfg (sink) writes the modulus, accepted on every cycle.
// A transfer on operand starts one computation; operand is not ready again
// until the result has been loaded into the output register.
// Each Euclid quotient step runs through one shared restoring divider that
// retires one quotient bit per cycle and accumulates quotient times the
// Bezout coefficient on the fly.
// A computation runs k quotient steps, at most about 46 for 32-bit words.
// no_inverse is set and inverse is 0 when gcd(value, modulus) is not 1 or
// the modulus is below two.
// Reset returns to idle, drops any pending result and sets the modulus to
// 1000000007 (truncated to WORD_WIDTH). When the receiver stalls, the
// result holds in the output register and the next operand may already be
// taken; its result waits until the previous one is transferred.
module modular_inverse_ext_euclid #(
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mie_in_if.sink    operand,
  mie_out_if.source result,
  mie_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(WORD_WIDTH);

  mie_pkg::state_t       state;
  mie_pkg::state_t       state_next;
  mie_pkg::div_ctrl_t    div_ctrl;

  logic [WORD_WIDTH-1:0] modulus;
  logic [WORD_WIDTH-1:0] r0;
  logic [WORD_WIDTH-1:0] r1;
  logic [WORD_WIDTH-1:0] s0;
  logic [WORD_WIDTH-1:0] s1;
  logic                  odd;
  logic [CNT_W-1:0]      cnt;
  logic                  out_valid;
  logic [WORD_WIDTH-1:0] inverse;
  logic                  no_inverse;

  logic [WORD_WIDTH-1:0] rem;
  logic [WORD_WIDTH-1:0] prod;
  logic [WORD_WIDTH-1:0] mag;
  logic                  has_inv;
  logic                  out_free;

  mie_div #(.WORD_WIDTH(WORD_WIDTH)) u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (r0),
    .divisor  (r1),
    .coef     (s1),
    .rem      (rem),
    .prod     (prod)
  );

  assign mag      = (s0 >= modulus) ? s0 - modulus : s0;
  assign has_inv  = (modulus >= WORD_WIDTH'(2)) && (r0 == WORD_WIDTH'(1));
  assign out_free = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      mie_pkg::ST_IDLE:   if (operand.valid) state_next = mie_pkg::ST_CHECK;
      mie_pkg::ST_CHECK:  state_next = (r1 == '0) ? mie_pkg::ST_NORM : mie_pkg::ST_DIV;
      mie_pkg::ST_DIV:    if (cnt == CNT_W'(WORD_WIDTH - 1)) state_next = mie_pkg::ST_UPDATE;
      mie_pkg::ST_UPDATE: state_next = mie_pkg::ST_CHECK;
      mie_pkg::ST_NORM:   state_next = mie_pkg::ST_FINAL;
      mie_pkg::ST_FINAL:  if (out_free) state_next = mie_pkg::ST_IDLE;
      default:            state_next = mie_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    operand.ready = (state == mie_pkg::ST_IDLE);
    div_ctrl.load = (state == mie_pkg::ST_CHECK);
    div_ctrl.step = (state == mie_pkg::ST_DIV);
  end

  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.inverse    = inverse;
  assign result.no_inverse = no_inverse;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mie_pkg::ST_IDLE;
      out_valid <= 1'b0;
      modulus   <= mie_pkg::MODULUS_RESET[WORD_WIDTH-1:0];
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        modulus <= cfg.data;
      end
      if (state == mie_pkg::ST_FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mie_pkg::ST_IDLE: begin
        r0  <= operand.value;
        r1  <= modulus;
        s0  <= WORD_WIDTH'(1);
        s1  <= '0;
        odd <= 1'b0;
      end
      mie_pkg::ST_CHECK: begin
        cnt <= '0;
      end
      mie_pkg::ST_DIV: begin
        cnt <= cnt + CNT_W'(1);
      end
      mie_pkg::ST_UPDATE: begin
        r0  <= r1;
        r1  <= rem;
        s0  <= s1;
        s1  <= s0 + prod;
        odd <= ~odd;
      end
      mie_pkg::ST_NORM: begin
        s0 <= mag;
      end
      mie_pkg::ST_FINAL: begin
        if (out_free) begin
          if (has_inv) begin
            inverse <= (odd && s0 != '0) ? modulus - s0 : s0;
          end else begin
            inverse <= '0;
          end
          no_inverse <= ~has_inv;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == mie_pkg::ST_DIV |-> r1 != '0)
    else $error("divider running with zero divisor");

  a_update_after_div: assert property (@(posedge clk) disable iff (rst)
    state == mie_pkg::ST_UPDATE |->
      $past(state) == mie_pkg::ST_DIV && $past(cnt) == CNT_W'(WORD_WIDTH - 1))
    else $error("update without a full division pass");

  a_inv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_inverse |-> inverse < modulus && inverse != '0)
    else $error("inverse out of range");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_inverse |-> inverse == '0)
    else $error("inverse not zero while flagged");
`endif

endmodule

/* bench/modular_inverse_ext_euclid_tb.sv */
module modular_inverse_ext_euclid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1700;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         no_inverse;
  } inverse_t;

  logic clk;
  logic rst;

  mie_in_if  #(.WORD_WIDTH(W)) operand_bus ();
  mie_out_if #(.WORD_WIDTH(W)) result_bus ();
  mie_cfg_if #(.WORD_WIDTH(W)) cfg_bus ();

  modular_inverse_ext_euclid #(
    .WORD_WIDTH(W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .operand(operand_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  logic [W-1:0] operand_queue[$];
  inverse_t     expected_inverses[$];
  logic [W-1:0] modulus_q;
  logic         operand_fire;
  inverse_t     want;
  inverse_t     got;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           idle_cycles;
  int           mismatches = 0;
  int           operands_sent = 0;
  int           results_checked = 0;
  int           modulus_writes = 0;

  function automatic inverse_t mod_inverse(logic [W-1:0] value, logic [W-1:0] m);
    logic [2*W-1:0] r0, r1, r2, s0, s1, s2, q, mag;
    bit             odd;
    inverse_t       res;
    res.inverse    = '0;
    res.no_inverse = 1'b1;
    if (m >= 2) begin
      r0  = (2*W)'(value);
      r1  = (2*W)'(m);
      s0  = 1;
      s1  = 0;
      odd = 1'b0;
      while (r1 != 0) begin
        q   = r0 / r1;
        r2  = r0 - q * r1;
        s2  = s0 + q * s1;
        r0  = r1;
        r1  = r2;
        s0  = s1;
        s1  = s2;
        odd = !odd;
      end
      if (r0 == 1) begin
        mag            = s0 % m;
        res.inverse    = (odd && mag != 0) ? W'(m - mag) : W'(mag);
        res.no_inverse = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [W-1:0] random_operand(logic [W-1:0] m);
    case ($urandom_range(7))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(m - 1);
      5:       return $urandom_range(16);
      6:       return m + $urandom_range(4) - 2;
      default: return (m >> $urandom_range(3)) * $urandom_range(5);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input inverse_t exp_v, input inverse_t act_v);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("mismatch (%s) at %0t: expected inverse %0d no_inverse %0b,",
               what, $realtime, exp_v.inverse, exp_v.no_inverse);
      $display("  got inverse %0d no_inverse %0b", act_v.inverse, act_v.no_inverse);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // operand driver
  always @(negedge clk) begin
    if (rst) begin
      operand_bus.valid <= 1'b0;
    end else if (!operand_bus.valid || operand_fire) begin
      if (operand_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        operand_bus.valid <= 1'b1;
        operand_bus.value <= operand_queue.pop_front();
      end else begin
        operand_bus.valid <= 1'b0;
        operand_bus.value <= $urandom;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    result_bus.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    operand_fire <= operand_bus.valid && operand_bus.ready;
    if (rst) begin
      modulus_q   <= mie_pkg::MODULUS_RESET[W-1:0];
      idle_cycles <= 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        modulus_q <= cfg_bus.data;
        modulus_writes++;
      end
      if (operand_bus.valid && operand_bus.ready) begin
        expected_inverses.push_back(mod_inverse(operand_bus.value, modulus_q));
        operands_sent++;
      end
      if (result_bus.valid && result_bus.ready) begin
        got.inverse    = result_bus.inverse;
        got.no_inverse = result_bus.no_inverse;
        results_checked++;
        if (expected_inverses.size() == 0) begin
          note_mismatch("no result pending", '0, got);
        end else begin
          want = expected_inverses.pop_front();
          if (want.inverse !== got.inverse || want.no_inverse !== got.no_inverse) begin
            note_mismatch("wrong field", want, got);
          end
        end
      end
      if ((cfg_bus.valid && cfg_bus.ready) || (operand_bus.valid && operand_bus.ready) ||
          (result_bus.valid && result_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    while (operand_queue.size() > 0 || operand_bus.valid || expected_inverses.size() > 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    wait_drained();
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_flow(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      operand_queue.push_back(random_operand(modulus_q));
    end
  endtask

  initial begin
    int missing;
    set_flow(0, 0);
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus, back-to-back
    operand_queue = '{32'd0, 32'd1, 32'd2, 32'd500000004, 32'd1000000006, 32'd1000000007,
                      32'd1000000008, 32'd2000000014, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'hFFFF_FFFF};
    add_random(40);
    wait_drained();

    write_modulus(32'd2);
    set_flow(77, 0);
    operand_queue = '{32'd0, 32'd1, 32'hFFFF_FFFF};
    add_random(30);

    write_modulus(32'hFFFF_FFFF);
    set_flow(0, 77);
    operand_queue = '{32'd0, 32'd1, 32'd3, 32'd65537, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    add_random(60);

    write_modulus(32'd1000);
    set_flow(34, 34);
    operand_queue = '{32'd10, 32'd999};
    add_random(50);

    // consecutive Fibonacci numbers give the longest quotient chain
    write_modulus(32'd2971215073);
    set_flow(0, 0);
    operand_queue = '{32'd1836311903, 32'd1134903170};
    add_random(30);

    write_modulus(32'h7FFF_FFFF);
    set_flow(77, 0);
    add_random(50);

    write_modulus(32'd4294967291);
    set_flow(0, 77);
    add_random(50);

    write_modulus($urandom_range(32'hFFFF_FFFF, 2));
    set_flow(34, 34);
    add_random(50);

    write_modulus(32'd12);
    set_flow(0, 0);
    add_random(20);

    write_modulus(mie_pkg::MODULUS_RESET[W-1:0]);
    set_flow(34, 34);
    add_random(20);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    missing = expected_inverses.size();
    if (missing > 0) begin
      $display("%0d expected results never arrived", missing);
    end
    $display("Run covered %0d operands and %0d checked results across %0d modulus writes,",
             operands_sent, results_checked, modulus_writes);
    $display("from back-to-back traffic to heavy sender gaps and receiver stalls.");
    if (mismatches == 0 && missing == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
